// File: sv/smpd_pkg.sv
// Package for the serial mouse packet decoder.
// Holds field widths, bit positions and the divider result type; depends on nothing.
package smpd_pkg;

    localparam int BYTE_W    = 8;
    localparam int DIV_W     = 7;
    localparam int SUM_W     = 9;
    localparam int DIV_STEPS = SUM_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int OUT_W     = 24;

    localparam int SYNC_POS  = 6;
    localparam int RIGHT_POS = 4;
    localparam int LEFT_POS  = 5;

    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_THIRD  = 2'd2;
    localparam logic [1:0] POS_UNUSED = 2'd3;

    localparam logic REG_X_DIV = 1'b0;
    localparam logic REG_Y_DIV = 1'b1;

    typedef struct packed {
        logic             done;
        logic [BYTE_W-1:0] rate;
        logic [BYTE_W-1:0] residue;
    } t_div_res;

endpackage

// File: sv/smpd_div.sv
// Bit-serial signed divider: one quotient bit per cycle, truncation toward zero.
// Depends on smpd_pkg for widths and the result struct.
module smpd_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [smpd_pkg::SUM_W-1:0]     i_dividend,
    input  logic [smpd_pkg::DIV_W-1:0]     i_divisor,
    output smpd_pkg::t_div_res             o_res
);

    logic                            r_busy, n_busy;
    logic                            r_done, n_done;
    logic [smpd_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic [smpd_pkg::SUM_W-1:0]      r_num, n_num;
    logic [smpd_pkg::SUM_W-1:0]      r_quo, n_quo;
    logic [smpd_pkg::DIV_W-1:0]      r_rem, n_rem;
    logic [smpd_pkg::DIV_W-1:0]      r_div, n_div;
    logic                            r_neg, n_neg;
    logic [smpd_pkg::DIV_W:0]        w_trial;
    logic                            w_ge;
    logic [smpd_pkg::BYTE_W-1:0]     w_neg_quo;

    always_comb begin
        w_trial = {r_rem, r_num[smpd_pkg::SUM_W-1]};
        w_ge    = (w_trial >= {1'b0, r_div});
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_num   = r_num;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_div   = r_div;
        n_neg   = r_neg;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_neg  = i_dividend[smpd_pkg::SUM_W-1];
            n_num  = i_dividend[smpd_pkg::SUM_W-1] ? (~i_dividend + 1'b1) : i_dividend;
            n_quo  = '0;
            n_rem  = '0;
            n_div  = (i_divisor <= smpd_pkg::DIV_W'(1)) ? smpd_pkg::DIV_W'(1) : i_divisor;
        end else if (r_busy) begin
            n_num = {r_num[smpd_pkg::SUM_W-2:0], 1'b0};
            n_quo = {r_quo[smpd_pkg::SUM_W-2:0], w_ge};
            n_rem = w_ge ? smpd_pkg::DIV_W'(w_trial - {1'b0, r_div})
                         : w_trial[smpd_pkg::DIV_W-1:0];
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == smpd_pkg::CNT_W'(smpd_pkg::DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
        r_neg <= n_neg;
    end

    // saturate the signed quotient to one byte
    always_comb begin
        w_neg_quo   = ~r_quo[smpd_pkg::BYTE_W-1:0] + 1'b1;
        o_res.done  = r_done;
        if (r_neg) begin
            o_res.rate    = (r_quo > smpd_pkg::SUM_W'(128)) ? 8'h80 : w_neg_quo;
            o_res.residue = ~{1'b0, r_rem} + 1'b1;
        end else begin
            o_res.rate    = (r_quo > smpd_pkg::SUM_W'(127)) ? 8'h7F
                                                          : r_quo[smpd_pkg::BYTE_W-1:0];
            o_res.residue = {1'b0, r_rem};
        end
    end

endmodule

// File: sv/serial_mouse_packet_decoder_unit.sv
// Top level of the serial mouse packet decoder: packet assembly, button and residue state.
// Depends on smpd_pkg and the bit-serial divider smpd_div.
//
// Channels: the slave stream takes one received byte per request in s_tdata, with the
// scroll-busy flag in s_tuser. Every third byte closes a packet and gives one report on
// the master stream; the sync-error flag travels in m_tuser. The config channel writes
// register 0 (x divisor) or 1 (y divisor), always ready.
// Timing: a sync-error or scroll-busy packet reports in the cycle after its third byte.
// A moving packet runs two divisions on one shared bit-serial divider, x and then y,
// and the report is registered when the y division is done.
// Input: the first two bytes of a packet are taken while in the receive state; the slave
// side is held after a moving packet's third byte until both divisions are done, the
// divider giving one quotient bit per cycle.
// Reset: byte position, buttons and residues clear; divisors return to 1 and 2.
// Stall: a waiting report sits in the output register while the next packet's first
// two bytes are taken; the third byte waits until the report has been taken.
module serial_mouse_packet_decoder_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [7:0]                    i_s_tdata,   // [7:0] rx_byte
    input  logic                          i_s_tuser,   // [0] scroll_busy
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [smpd_pkg::OUT_W-1:0]    o_m_tdata,   // [0] right_changed, [1] right_pressed,
                                                       // [2] left_changed, [3] left_pressed,
                                                       // [11:4] x_rate, [19:12] y_rate,
                                                       // [20] moving, [23:21] zero
    output logic                          o_m_tuser,   // [0] sync_error
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [smpd_pkg::DIV_W-1:0]    i_cfg_data
);

    typedef enum logic [2:0] {
        ST_RECV = 3'b001,
        ST_DIVX = 3'b010,
        ST_DIVY = 3'b100
    } t_state;

    t_state                          r_state;
    logic [1:0]                      r_pos;
    logic [smpd_pkg::BYTE_W-1:0]     r_first, r_second, r_third;
    logic [1:0]                      r_buttons;
    logic [smpd_pkg::BYTE_W-1:0]     r_x_res, r_y_res, r_x_rate;
    logic [smpd_pkg::DIV_W-1:0]      r_x_div, r_y_div;
    logic [3:0]                      r_flags;
    logic                            r_out_valid;
    logic                            r_out_sync;
    logic [smpd_pkg::OUT_W-1:0]      r_out_data;

    logic                            w_in_acc, w_third, w_sync_ok;
    logic [1:0]                      w_new_bs, w_chg;
    logic [smpd_pkg::BYTE_W-1:0]     w_x_move, w_y_move;
    logic [smpd_pkg::SUM_W-1:0]      w_x_sum, w_y_sum;
    logic                            w_div_start;
    logic [smpd_pkg::SUM_W-1:0]      w_div_num;
    logic [smpd_pkg::DIV_W-1:0]      w_div_den;
    smpd_pkg::t_div_res              w_div;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == ST_RECV) && !((r_pos == smpd_pkg::POS_THIRD) && r_out_valid);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;
    assign o_m_tuser   = r_out_sync;

    assign w_in_acc  = i_s_tvalid && o_s_tready;
    assign w_third   = w_in_acc && (r_pos == smpd_pkg::POS_THIRD);
    assign w_sync_ok = r_first[smpd_pkg::SYNC_POS];
    assign w_new_bs  = {r_first[smpd_pkg::LEFT_POS], r_first[smpd_pkg::RIGHT_POS]};
    assign w_chg     = w_new_bs ^ r_buttons;

    assign w_x_move = {r_first[1:0], r_second[5:0]};
    assign w_y_move = {r_first[3:2], r_third[5:0]};
    assign w_x_sum  = {w_x_move[7], w_x_move} + {r_x_res[7], r_x_res};
    assign w_y_sum  = {w_y_move[7], w_y_move} + {r_y_res[7], r_y_res};

    assign w_div_start = (w_third && w_sync_ok && !i_s_tuser)
                       || ((r_state == ST_DIVX) && w_div.done);
    assign w_div_num   = (r_state == ST_RECV) ? w_x_sum : w_y_sum;
    assign w_div_den   = (r_state == ST_RECV) ? r_x_div : r_y_div;

    smpd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_num),
        .i_divisor  (w_div_den),
        .o_res      (w_div)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RECV;
            r_pos       <= smpd_pkg::POS_FIRST;
            r_first     <= '0;
            r_second    <= '0;
            r_buttons   <= '0;
            r_x_res     <= '0;
            r_y_res     <= '0;
            r_x_div     <= smpd_pkg::DIV_W'(1);
            r_y_div     <= smpd_pkg::DIV_W'(2);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    smpd_pkg::REG_X_DIV: r_x_div <= i_cfg_data;
                    smpd_pkg::REG_Y_DIV: r_y_div <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_RECV: begin
                    if (w_in_acc) begin
                        unique case (r_pos)
                            smpd_pkg::POS_FIRST, smpd_pkg::POS_UNUSED: begin
                                r_first <= i_s_tdata;
                                r_pos   <= smpd_pkg::POS_SECOND;
                            end
                            smpd_pkg::POS_SECOND: begin
                                r_second <= i_s_tdata;
                                r_pos    <= smpd_pkg::POS_THIRD;
                            end
                            smpd_pkg::POS_THIRD: begin
                                r_third <= i_s_tdata;
                                r_pos   <= smpd_pkg::POS_FIRST;
                                if (!w_sync_ok) begin
                                    r_out_valid <= 1'b1;
                                    r_out_sync  <= 1'b1;
                                    r_out_data  <= {20'd0, r_buttons[1], 1'b0,
                                                    r_buttons[0], 1'b0};
                                end else begin
                                    r_buttons <= w_new_bs;
                                    r_flags   <= {w_new_bs[1], w_chg[1], w_new_bs[0], w_chg[0]};
                                    if (i_s_tuser) begin
                                        r_out_valid <= 1'b1;
                                        r_out_sync  <= 1'b0;
                                        r_out_data  <= {20'd0, w_new_bs[1], w_chg[1],
                                                        w_new_bs[0], w_chg[0]};
                                    end else begin
                                        r_state <= ST_DIVX;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_DIVX: begin
                    if (w_div.done) begin
                        r_x_rate <= w_div.rate;
                        r_x_res  <= w_div.residue;
                        r_state  <= ST_DIVY;
                    end
                end
                ST_DIVY: begin
                    if (w_div.done) begin
                        r_y_res     <= w_div.residue;
                        r_out_valid <= 1'b1;
                        r_out_sync  <= 1'b0;
                        r_out_data  <= {3'd0, ((r_x_rate != '0) || (w_div.rate != '0)),
                                        w_div.rate, r_x_rate, r_flags};
                        r_state     <= ST_RECV;
                    end
                end
                default: r_state <= ST_RECV;
            endcase
        end
    end

    a_ready_only_recv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> (r_state == ST_RECV))
        else $error("input ready outside receive state");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (r_state != ST_RECV))
        else $error("divider finished with no division pending");

    a_pos_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos != smpd_pkg::POS_UNUSED)
        else $error("byte position reached the unused code");

    a_sync_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> ((o_m_tdata[20:4] == '0) && !o_m_tdata[0]
                                       && !o_m_tdata[2]))
        else $error("sync error report carries movement or button change");

endmodule
